// ===== hw/rtl/aphs_pkg.sv =====
// Shared types, codes and arithmetic helpers of the ankle pair homing stepper.
package aphs_pkg;

  localparam int CMD_W  = 32;
  localparam int RD_W   = 20;
  localparam int GOAL_W = 18;
  localparam int DB_W   = 16;
  localparam int STEP_W = 16;
  localparam int LIM_W  = 20;
  localparam int CFG_W  = 20;
  localparam int CFG_AW = 2;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_DEADBAND    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_STEP_SIZE   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_VALID_LIMIT = 2'd2;

  localparam logic [DB_W-1:0]   DEADBAND_RST    = 16'd100;
  localparam logic [STEP_W-1:0] STEP_SIZE_RST   = 16'd164;
  localparam logic [LIM_W-1:0]  VALID_LIMIT_RST = 20'd262144;

  // Item kinds.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Homing phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ROLL  = 2'd1;
  localparam logic [1:0] PH_PITCH = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_STEPPED = 2'd0;
  localparam logic [1:0] ST_HELD    = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;
  localparam logic [1:0] ST_STARTED = 2'd3;

  typedef struct packed {
    logic                    cmd;
    logic                    left_side;
    logic [GOAL_W-1:0]       roll_target;
    logic [GOAL_W-1:0]       pitch_target;
    logic signed [CMD_W-1:0] start_inner_command;
    logic signed [CMD_W-1:0] start_outer_command;
    logic signed [RD_W-1:0]  inner_reading;
    logic signed [RD_W-1:0]  outer_reading;
  } aphs_in_req_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] inner_command;
    logic signed [CMD_W-1:0] outer_command;
    logic                    pair_is_left;
    logic [1:0]              status;
  } aphs_out_req_t;

  typedef struct packed {
    logic [1:0]              phase;
    logic                    side_left;
    logic [GOAL_W-1:0]       roll_goal;
    logic [GOAL_W-1:0]       pitch_goal;
    logic signed [CMD_W-1:0] inner_cmd;
    logic signed [CMD_W-1:0] outer_cmd;
  } aphs_state_t;

  typedef struct packed {
    logic [DB_W-1:0]   deadband;
    logic [STEP_W-1:0] step_size;
    logic [LIM_W-1:0]  valid_limit;
  } aphs_cfg_t;

  // Magnitude of a signed reading; the most negative value maps to 2^(RD_W-1).
  function automatic logic [RD_W-1:0] rd_mag(input logic signed [RD_W-1:0] r);
    return r[RD_W-1] ? RD_W'(-r) : RD_W'(r);
  endfunction

  // True when the reading magnitude lies within the deadband around the goal.
  function automatic logic in_band(input logic [RD_W-1:0] mag,
                                   input logic [GOAL_W-1:0] goal,
                                   input logic [DB_W-1:0] db);
    logic [RD_W:0] diff;
    logic [RD_W:0] offset;
    diff = {1'b0, mag} - {{(RD_W+1-GOAL_W){1'b0}}, goal};
    offset = diff[RD_W] ? (RD_W+1)'(-diff) : diff;
    return offset <= {{(RD_W+1-DB_W){1'b0}}, db};
  endfunction

  // Adds or removes one step and saturates at the signed command range.
  function automatic logic signed [CMD_W-1:0] sat_step(input logic signed [CMD_W-1:0] c,
                                                       input logic [STEP_W-1:0] s,
                                                       input logic down);
    logic [CMD_W+1:0] ce;
    logic [CMD_W+1:0] se;
    logic [CMD_W+1:0] sum;
    ce  = {{2{c[CMD_W-1]}}, c};
    se  = {{(CMD_W+2-STEP_W){1'b0}}, s};
    sum = down ? ce - se : ce + se;
    if (sum[CMD_W+1:CMD_W-1] == 3'b000 || sum[CMD_W+1:CMD_W-1] == 3'b111) begin
      return sum[CMD_W-1:0];
    end else if (sum[CMD_W+1]) begin
      return {1'b1, {(CMD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CMD_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hw/rtl/ankle_pair_homing_stepper.sv =====
// Top level of the two-phase homing stepper for a differential ankle pair.
// Each request passes through the input register and then the result register.
// Throughput: one request per cycle while out_stall_i is low; the only loop is the homing
// state, updated at the edge where the result register loads, so the next request sees it.
// Reset clears the homing state to idle with zero commands and loads the register
// defaults: deadband 100, step size 164, valid limit 262144.
module ankle_pair_homing_stepper import aphs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_AW-1:0]   cfg_addr_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  aphs_in_req_t        in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aphs_out_req_t       out_req_o
);

  // Configuration registers.
  aphs_cfg_t     cfg_q;

  // Input register stage.
  logic          s1_valid_q;
  aphs_in_req_t  s1_q;

  // Result register stage and the homing state it travels with.
  logic          out_valid_q;
  aphs_out_req_t out_q;
  aphs_state_t   state_q;
  aphs_state_t   state_d;
  aphs_out_req_t res_d;

  logic          out_load;
  logic          s1_move;
  logic          in_take;

  // The result register can take a new value when it is empty or being drained.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_load;
  // The input register frees up when empty or when its request moves on.
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband    <= DEADBAND_RST;
      cfg_q.step_size   <= STEP_SIZE_RST;
      cfg_q.valid_limit <= VALID_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DEADBAND:    cfg_q.deadband    <= cfg_wdata_i[DB_W-1:0];
        REG_STEP_SIZE:   cfg_q.step_size   <= cfg_wdata_i[STEP_W-1:0];
        REG_VALID_LIMIT: cfg_q.valid_limit <= cfg_wdata_i[LIM_W-1:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  aphs_step u_step (
    .req_i   (s1_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Control and homing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_move) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_req_i;
    end
    if (s1_move) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // A result only appears after a request sat in the input register.
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result valid without a request in the input stage");

  // A start request always leaves the block in the roll phase.
  a_start_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_q.cmd == CMD_START) |=> (state_q.phase == PH_ROLL &&
                                             out_q.status == ST_STARTED))
    else $error("start request did not enter the roll phase");

  // A held result leaves both commands untouched.
  a_held_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && res_d.status == ST_HELD) |=>
      (state_q.inner_cmd == $past(state_q.inner_cmd) &&
       state_q.outer_cmd == $past(state_q.outer_cmd)))
    else $error("commands changed on a held reading");

  // The unused phase code is never stored.
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE || state_q.phase == PH_ROLL || state_q.phase == PH_PITCH)
    else $error("illegal homing phase");

endmodule

// ===== hw/rtl/aphs_step.sv =====
// Next-state and result logic for one registered request.
module aphs_step import aphs_pkg::*; (
  input  aphs_in_req_t  req_i,
  input  aphs_state_t   state_i,
  input  aphs_cfg_t     cfg_i,
  output aphs_state_t   state_o,
  output aphs_out_req_t res_o
);

  logic [RD_W-1:0] inner_mag;
  logic [RD_W-1:0] outer_mag;
  logic            roll_done;
  logic            pitch_done;
  logic            inner_ok;
  logic            outer_ok;
  logic            inner_high;
  logic            outer_high;
  logic [1:0]      status;
  aphs_state_t     nxt;

  assign inner_mag  = rd_mag(req_i.inner_reading);
  assign outer_mag  = rd_mag(req_i.outer_reading);
  assign roll_done  = in_band(inner_mag, state_i.roll_goal, cfg_i.deadband);
  assign pitch_done = in_band(outer_mag, state_i.pitch_goal, cfg_i.deadband);
  assign inner_ok   = inner_mag < cfg_i.valid_limit;
  assign outer_ok   = outer_mag < cfg_i.valid_limit;
  assign inner_high = inner_mag > {{(RD_W-GOAL_W){1'b0}}, state_i.roll_goal};
  assign outer_high = outer_mag > {{(RD_W-GOAL_W){1'b0}}, state_i.pitch_goal};

  always_comb begin
    nxt    = state_i;
    status = ST_IDLE;
    if (req_i.cmd == CMD_START) begin
      nxt.side_left  = req_i.left_side;
      nxt.roll_goal  = req_i.roll_target;
      nxt.pitch_goal = req_i.pitch_target;
      nxt.inner_cmd  = req_i.start_inner_command;
      nxt.outer_cmd  = req_i.start_outer_command;
      nxt.phase      = PH_ROLL;
      status         = ST_STARTED;
    end else if (state_i.phase == PH_ROLL && !roll_done) begin
      if (inner_ok) begin
        nxt.inner_cmd = sat_step(state_i.inner_cmd, cfg_i.step_size, inner_high);
        nxt.outer_cmd = sat_step(state_i.outer_cmd, cfg_i.step_size, inner_high);
        status        = ST_STEPPED;
      end else begin
        status = ST_HELD;
      end
    end else if (state_i.phase == PH_ROLL || state_i.phase == PH_PITCH) begin
      // A finished roll phase falls through to the pitch test on the same sample.
      if (pitch_done) begin
        nxt.phase = PH_IDLE;
        status    = ST_IDLE;
      end else begin
        nxt.phase = PH_PITCH;
        if (outer_ok) begin
          nxt.inner_cmd = sat_step(state_i.inner_cmd, cfg_i.step_size, !outer_high);
          nxt.outer_cmd = sat_step(state_i.outer_cmd, cfg_i.step_size, outer_high);
          status        = ST_STEPPED;
        end else begin
          status = ST_HELD;
        end
      end
    end else begin
      nxt.phase = PH_IDLE;
    end
  end

  assign state_o             = nxt;
  assign res_o.inner_command = nxt.inner_cmd;
  assign res_o.outer_command = nxt.outer_cmd;
  assign res_o.pair_is_left  = nxt.side_left;
  assign res_o.status        = status;

endmodule

// ===== tb/sv/ankle_pair_homing_stepper_tb.sv =====
// Self-checking testbench for the ankle pair homing stepper: directed drill, then random phases.
module ankle_pair_homing_stepper_tb import aphs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     HALF_PERIOD = 5;
  localparam int     RESET_CYCLES = 9;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     PHASES = 10;
  localparam int     PHASE_REQUESTS = 100;
  localparam int     SETTLE_CYCLES = 4;
  localparam longint CMD_TOP = (longint'(1) << (CMD_W - 1)) - 1;
  localparam longint CMD_BOTTOM = -CMD_TOP - 1;
  localparam longint RD_SPAN = longint'(1) << (RD_W - 1);

  // One row of the directed drill. When typed is set, the expected result was worked
  // out by hand and is used as is; otherwise the homing predictor supplies it.
  typedef struct {
    aphs_in_req_t  req;
    bit            typed;
    aphs_out_req_t want;
  } drill_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  aphs_in_req_t  in_req_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  aphs_out_req_t out_req_o;

  ankle_pair_homing_stepper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Tracked homing state and register copies. These mirror what the block should
  // hold after every accepted request.
  logic [1:0]        trk_phase = PH_IDLE;
  logic              trk_left = 1'b0;
  longint            trk_roll = 0;
  longint            trk_pitch = 0;
  longint            trk_inner = 0;
  longint            trk_outer = 0;
  longint            cfg_deadband = DEADBAND_RST;
  longint            cfg_step = STEP_SIZE_RST;
  longint            cfg_limit = VALID_LIMIT_RST;

  aphs_out_req_t     pending_commands[$];
  drill_row_t        drill[$];
  int                mismatches = 0;
  int                cycle_count = 0;
  int                stall_left = 0;
  bit                steady_sender = 1'b0;

  // Saturating add of a signed step onto a motor command.
  function automatic longint nudge(longint c, longint d);
    longint sum;
    sum = c + d;
    if (sum > CMD_TOP) return CMD_TOP;
    if (sum < CMD_BOTTOM) return CMD_BOTTOM;
    return sum;
  endfunction

  function automatic longint reading_mag(logic signed [RD_W-1:0] v);
    longint x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  function automatic bit near_goal(longint mag, longint goal);
    longint offset;
    offset = mag - goal;
    if (offset < 0) offset = -offset;
    return offset <= cfg_deadband;
  endfunction

  // Advances the tracked homing state by one request and returns the result the
  // block must produce for it.
  function automatic aphs_out_req_t advance_homing(aphs_in_req_t r);
    aphs_out_req_t res;
    logic [1:0]    st;
    longint        mi;
    longint        mo;
    st = ST_IDLE;
    if (r.cmd == CMD_START) begin
      trk_left  = r.left_side;
      trk_roll  = r.roll_target;
      trk_pitch = r.pitch_target;
      trk_inner = longint'($signed(r.start_inner_command));
      trk_outer = longint'($signed(r.start_outer_command));
      trk_phase = PH_ROLL;
      st = ST_STARTED;
    end else begin
      mi = reading_mag(r.inner_reading);
      mo = reading_mag(r.outer_reading);
      // Roll phase: both motors move the same way. The deadband test comes before
      // the validity test, so an invalid reading can still end the phase.
      if (trk_phase == PH_ROLL) begin
        if (near_goal(mi, trk_roll)) begin
          trk_phase = PH_PITCH;
        end else if (mi < cfg_limit) begin
          if (mi > trk_roll) begin
            trk_outer = nudge(trk_outer, -cfg_step);
            trk_inner = nudge(trk_inner, -cfg_step);
          end else begin
            trk_outer = nudge(trk_outer, cfg_step);
            trk_inner = nudge(trk_inner, cfg_step);
          end
          st = ST_STEPPED;
        end else begin
          st = ST_HELD;
        end
      end
      // Pitch phase: the motors move against each other. A roll phase that has just
      // ended falls through to here on the same sample.
      if (trk_phase == PH_PITCH) begin
        if (near_goal(mo, trk_pitch)) begin
          trk_phase = PH_IDLE;
          st = ST_IDLE;
        end else if (mo < cfg_limit) begin
          if (mo > trk_pitch) begin
            trk_outer = nudge(trk_outer, -cfg_step);
            trk_inner = nudge(trk_inner, cfg_step);
          end else begin
            trk_outer = nudge(trk_outer, cfg_step);
            trk_inner = nudge(trk_inner, -cfg_step);
          end
          st = ST_STEPPED;
        end else begin
          st = ST_HELD;
        end
      end else if (trk_phase != PH_ROLL) begin
        trk_phase = PH_IDLE;
      end
    end
    res.inner_command = CMD_W'(trk_inner);
    res.outer_command = CMD_W'(trk_outer);
    res.pair_is_left  = trk_left;
    res.status        = st;
    return res;
  endfunction

  function automatic aphs_in_req_t start_req(logic left, longint roll, longint pitch,
                                             longint ic, longint oc);
    aphs_in_req_t r;
    r = '0;
    r.cmd = CMD_START;
    r.left_side = left;
    r.roll_target = GOAL_W'(roll);
    r.pitch_target = GOAL_W'(pitch);
    r.start_inner_command = CMD_W'(ic);
    r.start_outer_command = CMD_W'(oc);
    return r;
  endfunction

  function automatic aphs_in_req_t tick_req(longint inr, longint outr);
    aphs_in_req_t r;
    r = '0;
    r.cmd = CMD_TICK;
    r.inner_reading = RD_W'(inr);
    r.outer_reading = RD_W'(outr);
    return r;
  endfunction

  function automatic aphs_out_req_t result_of(longint ic, longint oc, logic left,
                                              logic [1:0] st);
    aphs_out_req_t res;
    res.inner_command = CMD_W'(ic);
    res.outer_command = CMD_W'(oc);
    res.pair_is_left = left;
    res.status = st;
    return res;
  endfunction

  // Appends one row to the directed drill.
  task automatic add_row(input aphs_in_req_t req, input bit typed,
                         input aphs_out_req_t want);
    drill_row_t row;
    row.req = req;
    row.typed = typed;
    row.want = want;
    drill.insert(drill.size(), row);
  endtask

  // Picks an encoder reading around a goal: often at the deadband edge, often a
  // valid reading further off, sometimes an invalid one, sometimes anything at all.
  function automatic logic signed [RD_W-1:0] aim_reading(longint goal);
    longint      m;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      m = goal - (cfg_deadband + 3) + longint'($urandom_range(32'(2 * (cfg_deadband + 3))));
    end else if (pick < 75) begin
      m = (cfg_limit > 1) ? longint'($urandom_range(32'(cfg_limit - 1))) : 0;
    end else if (pick < 88) begin
      m = cfg_limit + longint'($urandom_range(32'(RD_SPAN - cfg_limit)));
    end else begin
      m = longint'($urandom_range(32'(RD_SPAN)));
    end
    if (m < 0) m = 0;
    if (m > RD_SPAN) m = RD_SPAN;
    // Only the negative side can carry the full span.
    if (m == RD_SPAN || (m != 0 && $urandom_range(1) == 1)) return RD_W'(-m);
    return RD_W'(m);
  endfunction

  // Start command values: near either saturation limit so that steps clip, small, or any value.
  function automatic logic [CMD_W-1:0] start_command();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return CMD_W'(CMD_TOP - longint'($urandom_range(32'(3 * cfg_step))));
    if (pick < 30) return CMD_W'(CMD_BOTTOM + longint'($urandom_range(32'(3 * cfg_step))));
    if (pick < 90) return CMD_W'(longint'($urandom_range(400000)) - 200000);
    return CMD_W'($urandom);
  endfunction

  // Random request. Fields that the request kind ignores carry noise, so every
  // input bit toggles. Mostly well-formed homing sequences: a start, then ticks
  // whose readings land around the current goals.
  function automatic aphs_in_req_t random_request();
    aphs_in_req_t r;
    logic [159:0] noise;
    int unsigned  pick;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(aphs_in_req_t)-1:0];
    pick = $urandom_range(99);
    if ((trk_phase == PH_IDLE && pick < 80) || (trk_phase != PH_IDLE && pick < 6)) begin
      r.cmd = CMD_START;
      if ($urandom_range(9) < 4) begin
        r.roll_target = GOAL_W'($urandom_range(4000));
        r.pitch_target = GOAL_W'($urandom_range(4000));
      end
      r.start_inner_command = start_command();
      r.start_outer_command = start_command();
    end else begin
      r.cmd = CMD_TICK;
      if ($urandom_range(99) >= 5) begin
        r.inner_reading = aim_reading(trk_roll);
        r.outer_reading = aim_reading(trk_pitch);
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Presents one request and holds it until the block takes it. The expected
  // result is queued at the edge of acceptance. Valid stays high on return, so a
  // following request goes out back to back.
  task automatic send_request(input aphs_in_req_t r, input bit typed,
                              input aphs_out_req_t want);
    aphs_out_req_t predicted;
    in_req_i <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_homing(r);
    pending_commands.insert(pending_commands.size(), typed ? want : predicted);
  endtask

  // Random sender gap: mostly none, some short, a few long.
  task automatic sender_gap();
    int unsigned pick;
    int          gap;
    pick = $urandom_range(99);
    if (steady_sender || pick < 60) gap = 0;
    else if (pick < 90) gap = $urandom_range(3, 1);
    else if (pick < 98) gap = $urandom_range(10, 4);
    else gap = $urandom_range(60, 20);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every queued result has come back, then lets the
  // pipeline settle so the block is idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_commands.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges with the write enable held.
  task automatic program_regs(input longint db, input longint step, input longint lim);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= REG_DEADBAND;
    cfg_wdata_i <= CFG_W'(db);
    @(posedge clk_i);
    cfg_addr_i <= REG_STEP_SIZE;
    cfg_wdata_i <= CFG_W'(step);
    @(posedge clk_i);
    cfg_addr_i <= REG_VALID_LIMIT;
    cfg_wdata_i <= CFG_W'(lim);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_deadband = db;
    cfg_step = step;
    cfg_limit = lim;
  endtask

  // Receiver stall pattern: alternating free runs and stall runs of random length.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left <= ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(60, 10);
    end else begin
      out_stall_i <= 1'b1;
      if ($urandom_range(99) < 80) stall_left <= $urandom_range(2);
      else if ($urandom_range(99) < 75) stall_left <= $urandom_range(8, 3);
      else stall_left <= $urandom_range(40, 20);
    end
  end

  // Result checker: every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    aphs_out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_commands.size() == 0) begin
        note_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_commands.pop_front();
        if (out_req_o.inner_command !== want.inner_command)
          note_mismatch($sformatf("inner_command got %0d want %0d",
                                  out_req_o.inner_command, want.inner_command));
        if (out_req_o.outer_command !== want.outer_command)
          note_mismatch($sformatf("outer_command got %0d want %0d",
                                  out_req_o.outer_command, want.outer_command));
        if (out_req_o.pair_is_left !== want.pair_is_left)
          note_mismatch($sformatf("pair_is_left got %b want %b",
                                  out_req_o.pair_is_left, want.pair_is_left));
        if (out_req_o.status !== want.status)
          note_mismatch($sformatf("status got %0d want %0d",
                                  out_req_o.status, want.status));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ankle_pair_homing_stepper_tb: FAIL");
      $finish;
    end
  end

  initial begin
    aphs_in_req_t  req;
    aphs_out_req_t none;
    none = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed drill with the reset register values: deadband 100, step 164,
    // valid limit 262144.
    // A tick while idle only reports the stored (reset) commands.
    add_row(tick_req(0, 0), 1'b1, result_of(0, 0, 1'b0, ST_IDLE));
    add_row(start_req(1'b1, 1000, 2000, 100, -100), 1'b1,
            result_of(100, -100, 1'b1, ST_STARTED));
    // Roll phase, reading above the target, then below it.
    add_row(tick_req(5000, 0), 1'b1, result_of(-64, -264, 1'b1, ST_STEPPED));
    add_row(tick_req(-200, 0), 1'b1, result_of(100, -100, 1'b1, ST_STEPPED));
    // Invalid inner reading outside the deadband holds the commands.
    add_row(tick_req(300000, 0), 1'b1, result_of(100, -100, 1'b1, ST_HELD));
    // Roll target reached; the pitch test runs on the same sample and steps.
    add_row(tick_req(-1050, 5000), 1'b1, result_of(264, -264, 1'b1, ST_STEPPED));
    // Most negative outer reading is invalid.
    add_row(tick_req(RD_SPAN - 1, -RD_SPAN), 1'b1,
            result_of(264, -264, 1'b1, ST_HELD));
    // Pitch target reached exactly at the deadband edge.
    add_row(tick_req(0, 1900), 1'b1, result_of(264, -264, 1'b1, ST_IDLE));
    add_row(tick_req(7, 7), 1'b1, result_of(264, -264, 1'b1, ST_IDLE));
    // Both targets met by one sample: straight back to idle.
    add_row(start_req(1'b0, 0, 0, CMD_TOP - 255, CMD_BOTTOM + 80), 1'b1,
            result_of(CMD_TOP - 255, CMD_BOTTOM + 80, 1'b0, ST_STARTED));
    add_row(tick_req(0, 0), 1'b1,
            result_of(CMD_TOP - 255, CMD_BOTTOM + 80, 1'b0, ST_IDLE));
    // Upward saturation at the largest targets.
    add_row(start_req(1'b0, 262143, 262143, CMD_TOP - 47, CMD_TOP - 47), 1'b1,
            result_of(CMD_TOP - 47, CMD_TOP - 47, 1'b0, ST_STARTED));
    add_row(tick_req(0, 0), 1'b1, result_of(CMD_TOP, CMD_TOP, 1'b0, ST_STEPPED));
    // Invalid readings that still fall inside the deadband end both phases.
    add_row(tick_req(-262144, -262144), 1'b1,
            result_of(CMD_TOP, CMD_TOP, 1'b0, ST_IDLE));
    // Pitch phase in both directions, left pair; left to the predictor.
    add_row(start_req(1'b1, 500, 300, CMD_BOTTOM + 48, CMD_TOP - 47), 1'b1,
            result_of(CMD_BOTTOM + 48, CMD_TOP - 47, 1'b1, ST_STARTED));
    add_row(tick_req(0, 0), 1'b0, none);
    add_row(tick_req(520, 0), 1'b0, none);
    add_row(tick_req(0, RD_SPAN - 1), 1'b0, none);
    add_row(tick_req(0, 1000), 1'b0, none);
    // Start while homing reloads everything, here at the command minimum.
    add_row(start_req(1'b0, 0, 0, CMD_BOTTOM, CMD_BOTTOM), 1'b1,
            result_of(CMD_BOTTOM, CMD_BOTTOM, 1'b0, ST_STARTED));
    add_row(tick_req(RD_SPAN - 1, 0), 1'b1,
            result_of(CMD_BOTTOM, CMD_BOTTOM, 1'b0, ST_HELD));
    // Downward saturation.
    add_row(tick_req(5000, 0), 1'b1,
            result_of(CMD_BOTTOM, CMD_BOTTOM, 1'b0, ST_STEPPED));
    add_row(tick_req(50, -30), 1'b1,
            result_of(CMD_BOTTOM, CMD_BOTTOM, 1'b0, ST_IDLE));

    foreach (drill[i]) begin
      send_request(drill[i].req, drill[i].typed, drill[i].want);
      sender_gap();
    end

    // Random phases. Registers change only once the block has gone quiet. The first
    // two phases sit at the register extremes, the third back at the reset values.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: program_regs(0, 1, 1);
        1: program_regs(65535, 65535, RD_SPAN);
        2: program_regs(DEADBAND_RST, STEP_SIZE_RST, VALID_LIMIT_RST);
        default: program_regs(($urandom_range(3) == 0) ? $urandom_range(65535)
                                                       : $urandom_range(500),
                              ($urandom_range(3) == 0) ? $urandom_range(65535, 1)
                                                       : $urandom_range(2000, 1),
                              ($urandom_range(1) == 0) ? $urandom_range(32'(RD_SPAN), 1)
                                                       : $urandom_range(300000, 200000));
      endcase
      steady_sender = (ph % 3 == 1);
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        req = random_request();
        send_request(req, 1'b0, none);
        // Halfway through one phase, hold the sender until everything is back.
        if (ph == 4 && k == PHASE_REQUESTS / 2) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_commands.size() != 0);
        end else begin
          sender_gap();
        end
      end
    end

    drain_results();
    if (mismatches == 0 && pending_commands.size() == 0) begin
      $display("ankle_pair_homing_stepper_tb: PASS");
    end else begin
      $display("ankle_pair_homing_stepper_tb: FAIL");
    end
    $finish;
  end

endmodule
